>>> sv/tgc_pkg.sv
package tgc_pkg;

    // Field widths
    localparam int FingerW = 4;
    localparam int PosW    = 12;
    localparam int TimeW   = 32;
    localparam int StepW   = 10;
    localparam int DeltaW  = PosW + 1;   // signed displacement from origin
    localparam int AnchorW = PosW + 2;   // signed anchor

    // Default pointer clamp
    localparam int MaxPointsDefault = 8;

    // Register reset values
    localparam logic             EnableReset = 1'b1;
    localparam logic [StepW-1:0] StepReset   = 10'd40;
    localparam logic [StepW-1:0] StepMin     = 10'd8;

    // Release windows in ms
    localparam logic [TimeW-1:0] PauseWindow = 32'd500;
    localparam logic [TimeW-1:0] FlickWindow = 32'd350;
    localparam logic [TimeW-1:0] TapWindow   = 32'd300;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_ENABLE    = 1'b0,
        CFG_CELL_STEP = 1'b1
    } cfg_index_t;

    // Drag classification of the running sequence
    typedef enum logic [1:0] {
        DRAG_UNDECIDED = 2'd0,
        DRAG_HORIZ     = 2'd1,
        DRAG_DOWN      = 2'd2
    } drag_mode_t;

endpackage

>>> sv/touch_gesture_classifier.sv
// Each item passes the input register, then the result register, before it is offered on m_valid.
// Throughput: one item per cycle while m_ready is high; a new item is still taken while a
// result waits for m_ready, since the input and result registers form a two-deep pipeline.
// Reset (aresetn low, synchronous): both pipeline stages empty, enable = 1,
// cell_step = 40, touch sequence idle with all tracking state cleared.
module touch_gesture_classifier #(
    parameter int MAX_POINTS = tgc_pkg::MaxPointsDefault
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         cfg_wr_en,
    input  logic [0:0]                   cfg_index,
    input  logic [tgc_pkg::StepW-1:0]    cfg_wdata,

    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [tgc_pkg::FingerW-1:0]  s_finger_count,
    input  logic [tgc_pkg::PosW-1:0]     s_pos_x,
    input  logic [tgc_pkg::PosW-1:0]     s_pos_y,
    input  logic                         s_release_valid,
    input  logic [tgc_pkg::TimeW-1:0]    s_time_ms,

    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_move_left,
    output logic                         m_move_right,
    output logic                         m_soft_drop,
    output logic                         m_hard_drop,
    output logic                         m_pause_request,
    output logic                         m_tap,
    output logic [tgc_pkg::PosW-1:0]     m_tap_x,
    output logic [tgc_pkg::PosW-1:0]     m_tap_y,
    output logic                         m_any_action
);

    localparam int PW = tgc_pkg::PosW;
    localparam int DW = tgc_pkg::DeltaW;
    localparam int AW = tgc_pkg::AnchorW;
    localparam int SW = tgc_pkg::StepW;
    localparam int TW = tgc_pkg::TimeW;
    localparam logic [tgc_pkg::FingerW-1:0] MaxFingers = tgc_pkg::FingerW'(MAX_POINTS);

    // Configuration registers
    logic          enable_reg;
    logic [SW-1:0] cell_step_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg    <= tgc_pkg::EnableReset;
            cell_step_reg <= tgc_pkg::StepReset;
        end else if (cfg_wr_en) begin
            unique case (tgc_pkg::cfg_index_t'(cfg_index))
                tgc_pkg::CFG_ENABLE:    enable_reg    <= cfg_wdata[0];
                tgc_pkg::CFG_CELL_STEP: cell_step_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Pipeline handshake
    logic in_valid_reg;
    logic out_valid_reg;
    logic advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) in_valid_reg <= s_valid;
            if (advance) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
        end
    end

    // Input register
    logic [tgc_pkg::FingerW-1:0] fingers_in_reg;
    logic [PW-1:0]               px_reg;
    logic [PW-1:0]               py_reg;
    logic                        rel_reg;
    logic [TW-1:0]               now_reg;

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            fingers_in_reg <= s_finger_count;
            px_reg         <= s_pos_x;
            py_reg         <= s_pos_y;
            rel_reg        <= s_release_valid;
            now_reg        <= s_time_ms;
        end
    end

    // Sequence tracking state
    logic                        seq_active_reg, seq_active_next;
    logic [PW-1:0]               origin_x_reg, origin_x_next;
    logic [PW-1:0]               origin_y_reg, origin_y_next;
    logic signed [AW-1:0]        anchor_pos_reg, anchor_pos_next;
    logic [TW-1:0]               start_time_reg, start_time_next;
    tgc_pkg::drag_mode_t         drag_mode_reg, drag_mode_next;
    logic [tgc_pkg::FingerW-1:0] peak_fingers_reg, peak_fingers_next;
    logic signed [DW-1:0]        recent_dy_reg, recent_dy_next;
    logic [PW-1:0]               last_x_reg, last_x_next;
    logic [PW-1:0]               last_y_reg, last_y_next;

    // Result values
    logic          left_c, right_c, soft_c, hard_c, pause_c, tap_c;
    logic [PW-1:0] tx_c, ty_c;

    // Working values
    logic [tgc_pkg::FingerW-1:0] fingers_c;
    logic [SW-1:0]               step_c;
    logic signed [DW-1:0]        dx_c, dy_c;
    logic [PW-1:0]               ax_c;
    logic [PW+4:0]               ax20_c;     // ax * 20
    logic [SW+3:0]               step11_c;   // step * 11
    logic signed [DW+4:0]        dy20_c;     // dy * 20
    logic signed [DW+4:0]        step16_c;   // step * 16
    logic signed [AW:0]          d_c;        // px - anchor
    logic signed [AW:0]          step_s_c;
    logic [TW-1:0]               dur_c;
    logic [8:0]                  dur9_c;
    logic [SW+8:0]               step_dur_c; // step * dur
    logic signed [23:0]          rate_lhs_c; // recent_dy * 1000
    logic signed [23:0]          rate_rhs_c; // 6 * step * dur
    logic signed [DW+4:0]        rdy20_c;    // recent_dy * 20
    logic signed [DW+4:0]        step24_c;   // step * 24

    always_comb begin
        fingers_c = (fingers_in_reg > MaxFingers) ? MaxFingers : fingers_in_reg;
        step_c    = (cell_step_reg < tgc_pkg::StepMin) ? tgc_pkg::StepMin : cell_step_reg;

        seq_active_next   = seq_active_reg;
        origin_x_next     = origin_x_reg;
        origin_y_next     = origin_y_reg;
        anchor_pos_next   = anchor_pos_reg;
        start_time_next   = start_time_reg;
        drag_mode_next    = drag_mode_reg;
        peak_fingers_next = peak_fingers_reg;
        recent_dy_next    = recent_dy_reg;
        last_x_next       = last_x_reg;
        last_y_next       = last_y_reg;

        left_c  = 1'b0;
        right_c = 1'b0;
        soft_c  = 1'b0;
        hard_c  = 1'b0;
        pause_c = 1'b0;
        tap_c   = 1'b0;
        tx_c    = '0;
        ty_c    = '0;

        // Track the latest position, or the mouse release point
        if (fingers_c != '0 || rel_reg) begin
            last_x_next = px_reg;
            last_y_next = py_reg;
        end

        // Sequence start
        if (fingers_c != '0 && !seq_active_reg) begin
            seq_active_next   = 1'b1;
            origin_x_next     = px_reg;
            origin_y_next     = py_reg;
            anchor_pos_next   = $signed({2'b00, px_reg});
            start_time_next   = now_reg;
            drag_mode_next    = tgc_pkg::DRAG_UNDECIDED;
            peak_fingers_next = '0;
        end
        if (fingers_c != '0 && fingers_c > peak_fingers_next) peak_fingers_next = fingers_c;

        // Drag classification and stepping
        dx_c     = $signed({1'b0, px_reg}) - $signed({1'b0, origin_x_next});
        dy_c     = $signed({1'b0, py_reg}) - $signed({1'b0, origin_y_next});
        ax_c     = dx_c[DW-1] ? PW'(-dx_c) : PW'(dx_c);
        ax20_c   = (PW+5)'(ax_c) * (PW+5)'(20);
        step11_c = (SW+4)'(step_c) * (SW+4)'(11);
        dy20_c   = (DW+5)'(dy_c) * $signed((DW+5)'(20));
        step16_c = $signed({4'b0, step_c, 4'b0});
        step_s_c = $signed({5'b0, step_c});

        if (fingers_c != '0 && peak_fingers_next < 4'd2) begin
            if (drag_mode_next == tgc_pkg::DRAG_UNDECIDED) begin
                if ((ax20_c > (PW+5)'(step11_c)) &&
                    ($signed({2'b00, ax_c}) > (DW+1)'(dy_c)))
                    drag_mode_next = tgc_pkg::DRAG_HORIZ;
                else if (dy20_c > step16_c)
                    drag_mode_next = tgc_pkg::DRAG_DOWN;
            end
            d_c = $signed({3'b000, px_reg}) - (AW+1)'(anchor_pos_next);
            if (drag_mode_next == tgc_pkg::DRAG_HORIZ) begin
                if (d_c >= step_s_c) begin
                    right_c         = 1'b1;
                    anchor_pos_next = anchor_pos_next + $signed({4'b0, step_c});
                end else if (d_c <= -step_s_c) begin
                    left_c          = 1'b1;
                    anchor_pos_next = anchor_pos_next - $signed({4'b0, step_c});
                end
            end
            if (drag_mode_next == tgc_pkg::DRAG_DOWN) soft_c = 1'b1;
            recent_dy_next = dy_c;
        end else begin
            d_c = '0;
        end

        // Release decision
        dur_c      = now_reg - start_time_reg;
        dur9_c     = dur_c[8:0];
        step_dur_c = (SW+9)'(step_c) * (SW+9)'(dur9_c);
        rate_rhs_c = $signed({3'b000, step_dur_c, 2'b00} + {4'b0000, step_dur_c, 1'b0});
        rate_lhs_c = 24'(recent_dy_reg) * $signed(24'd1000);
        rdy20_c    = (DW+5)'(recent_dy_reg) * $signed((DW+5)'(20));
        step24_c   = $signed({4'b0, step_c, 4'b0}) + $signed({5'b0, step_c, 3'b0});

        if (fingers_c == '0 && seq_active_reg) begin
            if (peak_fingers_reg >= 4'd2) begin
                if (dur_c < tgc_pkg::PauseWindow) pause_c = 1'b1;
            end else if (drag_mode_reg == tgc_pkg::DRAG_DOWN &&
                         dur_c < tgc_pkg::FlickWindow &&
                         rdy20_c > step24_c && rate_lhs_c > rate_rhs_c) begin
                hard_c = 1'b1;
            end else if (drag_mode_reg == tgc_pkg::DRAG_UNDECIDED &&
                         dur_c < tgc_pkg::TapWindow) begin
                tap_c = 1'b1;
                tx_c  = last_x_next;
                ty_c  = last_y_next;
            end
            seq_active_next = 1'b0;
        end
    end

    // State update, frozen while disabled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_active_reg   <= 1'b0;
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            anchor_pos_reg   <= '0;
            start_time_reg   <= '0;
            drag_mode_reg    <= tgc_pkg::DRAG_UNDECIDED;
            peak_fingers_reg <= '0;
            recent_dy_reg    <= '0;
            last_x_reg       <= '0;
            last_y_reg       <= '0;
        end else if (advance && enable_reg) begin
            seq_active_reg   <= seq_active_next;
            origin_x_reg     <= origin_x_next;
            origin_y_reg     <= origin_y_next;
            anchor_pos_reg   <= anchor_pos_next;
            start_time_reg   <= start_time_next;
            drag_mode_reg    <= drag_mode_next;
            peak_fingers_reg <= peak_fingers_next;
            recent_dy_reg    <= recent_dy_next;
            last_x_reg       <= last_x_next;
            last_y_reg       <= last_y_next;
        end
    end

    // Result register
    logic          left_reg, right_reg, soft_reg, hard_reg, pause_reg, tap_reg;
    logic [PW-1:0] tx_reg, ty_reg;

    always_ff @(posedge aclk) begin
        if (advance) begin
            left_reg  <= enable_reg & left_c;
            right_reg <= enable_reg & right_c;
            soft_reg  <= enable_reg & soft_c;
            hard_reg  <= enable_reg & hard_c;
            pause_reg <= enable_reg & pause_c;
            tap_reg   <= enable_reg & tap_c;
            tx_reg    <= enable_reg ? tx_c : '0;
            ty_reg    <= enable_reg ? ty_c : '0;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_move_left     = left_reg;
    assign m_move_right    = right_reg;
    assign m_soft_drop     = soft_reg;
    assign m_hard_drop     = hard_reg;
    assign m_pause_request = pause_reg;
    assign m_tap           = tap_reg;
    assign m_tap_x         = tx_reg;
    assign m_tap_y         = ty_reg;
    assign m_any_action    = hard_reg | pause_reg | tap_reg;

endmodule

>>> verif/touch_gesture_classifier_tb.sv
module touch_gesture_classifier_tb;

    localparam int CycleLimit = 400000;
    localparam int PointCap   = tgc_pkg::MaxPointsDefault;

    // One touch sample as the sender presents it
    typedef struct {
        logic [tgc_pkg::FingerW-1:0] fingers;
        logic [tgc_pkg::PosW-1:0]    x;
        logic [tgc_pkg::PosW-1:0]    y;
        logic                        rel;
        logic [tgc_pkg::TimeW-1:0]   stamp;
    } touch_frame_t;

    // One classifier verdict
    typedef struct packed {
        logic                     move_left;
        logic                     move_right;
        logic                     soft_drop;
        logic                     hard_drop;
        logic                     pause_request;
        logic                     tap;
        logic [tgc_pkg::PosW-1:0] tap_x;
        logic [tgc_pkg::PosW-1:0] tap_y;
        logic                     any_action;
    } gesture_result_t;

    localparam gesture_result_t NoAction = '0;

    // Directed stimulus row; the verdict is typed in only where "fixed" is set
    typedef struct {
        touch_frame_t    frame;
        bit              fixed;
        gesture_result_t want;
    } frame_row_t;

    logic                        aclk = 1'b0;
    logic                        aresetn;
    logic                        cfg_wr_en;
    logic [0:0]                  cfg_index;
    logic [tgc_pkg::StepW-1:0]   cfg_wdata;
    logic                        s_valid;
    logic                        s_ready;
    logic [tgc_pkg::FingerW-1:0] s_finger_count;
    logic [tgc_pkg::PosW-1:0]    s_pos_x;
    logic [tgc_pkg::PosW-1:0]    s_pos_y;
    logic                        s_release_valid;
    logic [tgc_pkg::TimeW-1:0]   s_time_ms;
    logic                        m_valid;
    logic                        m_ready;
    logic                        m_move_left;
    logic                        m_move_right;
    logic                        m_soft_drop;
    logic                        m_hard_drop;
    logic                        m_pause_request;
    logic                        m_tap;
    logic [tgc_pkg::PosW-1:0]    m_tap_x;
    logic [tgc_pkg::PosW-1:0]    m_tap_y;
    logic                        m_any_action;

    // Verdicts still owed by the block, oldest first
    gesture_result_t expected_gestures[$];
    frame_row_t      directed_rows[$];
    gesture_result_t got_result;
    int              mismatches   = 0;
    int              frames_sent  = 0;
    int              cycle_count  = 0;
    bit              no_idle      = 1'b0;
    logic [tgc_pkg::TimeW-1:0] frame_clock_ms;

    // Tracker copy: configuration and touch sequence state
    bit                        cfg_en;
    logic [tgc_pkg::StepW-1:0] cfg_step;
    bit                        trk_active;
    int                        org_x, org_y, trk_anchor, peak_fingers, last_dy;
    logic [tgc_pkg::TimeW-1:0] t_start;
    tgc_pkg::drag_mode_t       mode;
    logic [tgc_pkg::PosW-1:0]  last_x, last_y;

    always #10 aclk = ~aclk;

    touch_gesture_classifier uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_finger_count  (s_finger_count),
        .s_pos_x         (s_pos_x),
        .s_pos_y         (s_pos_y),
        .s_release_valid (s_release_valid),
        .s_time_ms       (s_time_ms),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_move_left     (m_move_left),
        .m_move_right    (m_move_right),
        .m_soft_drop     (m_soft_drop),
        .m_hard_drop     (m_hard_drop),
        .m_pause_request (m_pause_request),
        .m_tap           (m_tap),
        .m_tap_x         (m_tap_x),
        .m_tap_y         (m_tap_y),
        .m_any_action    (m_any_action)
    );

    // Tracker: one sample in, one verdict out, state updated
    function automatic gesture_result_t advance_tracker(input touch_frame_t f);
        gesture_result_t           res;
        int                        n, stp, dx, dy, ax, d;
        logic [tgc_pkg::TimeW-1:0] dur;
        longint                    dur_l, dy_l, stp_l;
        res = NoAction;
        if (!cfg_en) return res;
        n   = (f.fingers > PointCap) ? PointCap : int'(f.fingers);
        stp = (cfg_step < tgc_pkg::StepMin) ? int'(tgc_pkg::StepMin) : int'(cfg_step);
        if (n > 0 || f.rel) begin
            last_x = f.x;
            last_y = f.y;
        end
        if (n > 0) begin
            if (!trk_active) begin
                trk_active   = 1'b1;
                org_x        = int'(f.x);
                org_y        = int'(f.y);
                trk_anchor   = int'(f.x);
                t_start      = f.stamp;
                mode         = tgc_pkg::DRAG_UNDECIDED;
                peak_fingers = 0;
            end
            if (n > peak_fingers) peak_fingers = n;
            // movement is only tracked while a single finger has been seen
            if (peak_fingers < 2) begin
                dx = int'(f.x) - org_x;
                dy = int'(f.y) - org_y;
                if (mode == tgc_pkg::DRAG_UNDECIDED) begin
                    ax = (dx < 0) ? -dx : dx;
                    if (ax * 20 > stp * 11 && ax > dy) mode = tgc_pkg::DRAG_HORIZ;
                    else if (dy * 20 > stp * 16) mode = tgc_pkg::DRAG_DOWN;
                end
                if (mode == tgc_pkg::DRAG_HORIZ) begin
                    d = int'(f.x) - trk_anchor;
                    if (d >= stp) begin
                        res.move_right = 1'b1;
                        trk_anchor += stp;
                    end else if (d <= -stp) begin
                        res.move_left = 1'b1;
                        trk_anchor -= stp;
                    end
                end
                if (mode == tgc_pkg::DRAG_DOWN) res.soft_drop = 1'b1;
                last_dy = dy;
            end
        end else if (trk_active) begin
            // release decision, durations modulo 2^32
            dur   = f.stamp - t_start;
            dur_l = longint'(dur);
            dy_l  = longint'(last_dy);
            stp_l = longint'(stp);
            if (peak_fingers >= 2) begin
                if (dur < tgc_pkg::PauseWindow) res.pause_request = 1'b1;
            end else if (mode == tgc_pkg::DRAG_DOWN && dur < tgc_pkg::FlickWindow &&
                         dy_l * 20 > stp_l * 24 && dy_l * 1000 > 6 * stp_l * dur_l) begin
                res.hard_drop = 1'b1;
            end else if (mode == tgc_pkg::DRAG_UNDECIDED && dur < tgc_pkg::TapWindow) begin
                res.tap   = 1'b1;
                res.tap_x = last_x;
                res.tap_y = last_y;
            end
            trk_active = 1'b0;
        end
        res.any_action = res.hard_drop | res.pause_request | res.tap;
        return res;
    endfunction

    function automatic int draw_idle();
        return no_idle ? 0 : int'($urandom_range(0, 9));
    endfunction

    function automatic int jitter(input int r);
        return int'($urandom_range(0, 2 * r)) - r;
    endfunction

    function automatic int clamp_pos(input int v);
        return (v < 0) ? 0 : ((v > 4095) ? 4095 : v);
    endfunction

    task automatic check_field(input string name, input logic [tgc_pkg::PosW-1:0] want,
                               input logic [tgc_pkg::PosW-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic add_row(input int fingers, input int x, input int y, input bit rel,
                           input logic [tgc_pkg::TimeW-1:0] stamp, input bit fixed,
                           input gesture_result_t want);
        frame_row_t r;
        r.frame.fingers = tgc_pkg::FingerW'(fingers);
        r.frame.x       = tgc_pkg::PosW'(x);
        r.frame.y       = tgc_pkg::PosW'(y);
        r.frame.rel     = rel;
        r.frame.stamp   = stamp;
        r.fixed         = fixed;
        r.want          = want;
        directed_rows.push_back(r);
    endtask

    // Present one item, hold it until accepted, then log what it should give
    task automatic push_frame(input touch_frame_t f, input bit fixed,
                              input gesture_result_t want);
        int              gap;
        gesture_result_t pred;
        gap = draw_idle();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_finger_count  <= f.fingers;
        s_pos_x         <= f.x;
        s_pos_y         <= f.y;
        s_release_valid <= f.rel;
        s_time_ms       <= f.stamp;
        do @(posedge aclk); while (!s_ready);
        pred = advance_tracker(f);
        expected_gestures.push_back(fixed ? want : pred);
        frames_sent++;
    endtask

    // Stop sending and wait until every owed verdict has come back
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_gestures.size() != 0);
    endtask

    task automatic write_reg(input tgc_pkg::cfg_index_t idx,
                             input logic [tgc_pkg::StepW-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        if (idx == tgc_pkg::CFG_ENABLE) cfg_en = val[0];
        else cfg_step = val;
    endtask

    // One touch sequence: tap, horizontal drag, downward drag, multi-finger,
    // or a few frames of noise; sometimes left without a release
    task automatic play_gesture(input int stp);
        int           kind, frames, px, py, dt_max;
        touch_frame_t f;
        kind    = $urandom_range(0, 9);
        no_idle = ($urandom_range(0, 4) == 0);
        dt_max  = $urandom_range(0, 1) ? 40 : 160;
        if ($urandom_range(0, 19) == 0) frame_clock_ms = 32'hFFFF_FE00 + $urandom_range(0, 511);
        if (kind >= 8) begin
            repeat ($urandom_range(1, 3)) begin
                f.fingers = tgc_pkg::FingerW'($urandom_range(0, 15));
                f.x       = tgc_pkg::PosW'($urandom_range(0, 4095));
                f.y       = tgc_pkg::PosW'($urandom_range(0, 4095));
                f.rel     = 1'($urandom_range(0, 1));
                f.stamp   = $urandom();
                push_frame(f, 1'b0, NoAction);
            end
            return;
        end
        px     = $urandom_range(0, 4095);
        py     = $urandom_range(0, 4095);
        frames = $urandom_range(1, 8);
        repeat (frames) begin
            f.fingers = tgc_pkg::FingerW'(1);
            if ((kind == 7 && $urandom_range(0, 2) == 0) || $urandom_range(0, 29) == 0)
                f.fingers = tgc_pkg::FingerW'($urandom_range(2, 15));
            f.x     = tgc_pkg::PosW'(px);
            f.y     = tgc_pkg::PosW'(py);
            f.rel   = 1'($urandom_range(0, 1));
            f.stamp = frame_clock_ms;
            push_frame(f, 1'b0, NoAction);
            frame_clock_ms += $urandom_range(0, dt_max);
            case (kind)
                3, 4: begin
                    px += jitter(stp * 3 / 2);
                    py += jitter(stp / 4);
                end
                5, 6: begin
                    px += jitter(stp / 4);
                    py += int'($urandom_range(0, 2 * stp)) - stp / 8;
                end
                default: begin
                    px += jitter(stp / 3);
                    py += jitter(stp / 3);
                end
            endcase
            px = clamp_pos(px);
            py = clamp_pos(py);
        end
        // release, with a random release point
        if ($urandom_range(0, 7) != 0) begin
            f.fingers = '0;
            f.x       = tgc_pkg::PosW'($urandom_range(0, 4095));
            f.y       = tgc_pkg::PosW'($urandom_range(0, 4095));
            f.rel     = 1'($urandom_range(0, 1));
            f.stamp   = frame_clock_ms;
            push_frame(f, 1'b0, NoAction);
        end
        frame_clock_ms += $urandom_range(0, 1000);
    endtask

    // Result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_gestures.size() == 0) begin
                $display("%0t: unexpected item on result channel (any_action %0d)",
                         $time, m_any_action);
                mismatches++;
            end else begin
                got_result = expected_gestures.pop_front();
                check_field("move_left", tgc_pkg::PosW'(got_result.move_left),
                            tgc_pkg::PosW'(m_move_left));
                check_field("move_right", tgc_pkg::PosW'(got_result.move_right),
                            tgc_pkg::PosW'(m_move_right));
                check_field("soft_drop", tgc_pkg::PosW'(got_result.soft_drop),
                            tgc_pkg::PosW'(m_soft_drop));
                check_field("hard_drop", tgc_pkg::PosW'(got_result.hard_drop),
                            tgc_pkg::PosW'(m_hard_drop));
                check_field("pause_request", tgc_pkg::PosW'(got_result.pause_request),
                            tgc_pkg::PosW'(m_pause_request));
                check_field("tap", tgc_pkg::PosW'(got_result.tap), tgc_pkg::PosW'(m_tap));
                check_field("tap_x", got_result.tap_x, m_tap_x);
                check_field("tap_y", got_result.tap_y, m_tap_y);
                check_field("any_action", tgc_pkg::PosW'(got_result.any_action),
                            tgc_pkg::PosW'(m_any_action));
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: random stall before each item
    initial begin
        int stall;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = draw_idle();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // Main sequence
    initial begin
        int                        target, stp;
        bit                        en;
        logic [tgc_pkg::StepW-1:0] step_val;
        aresetn         <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_index       <= tgc_pkg::CFG_ENABLE;
        cfg_wdata       <= '0;
        s_valid         <= 1'b0;
        s_finger_count  <= '0;
        s_pos_x         <= '0;
        s_pos_y         <= '0;
        s_release_valid <= 1'b0;
        s_time_ms       <= '0;

        // tracker in its reset state
        cfg_en       = tgc_pkg::EnableReset;
        cfg_step     = tgc_pkg::StepReset;
        trk_active   = 1'b0;
        org_x        = 0;
        org_y        = 0;
        trk_anchor   = 0;
        t_start      = '0;
        mode         = tgc_pkg::DRAG_UNDECIDED;
        peak_fingers = 0;
        last_dy      = 0;
        last_x       = '0;
        last_y       = '0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at reset settings (step 40)
        // idle releases, with and without a release point
        add_row(0, 0, 0, 0, 32'd0, 1, NoAction);
        add_row(0, 4095, 4095, 1, 32'hFFFF_FFFF, 1, NoAction);
        // plain tap; release position ignored without release_valid
        add_row(1, 100, 200, 0, 32'd1000, 1, NoAction);
        add_row(0, 7, 7, 0, 32'd1100, 1,
                '{tap: 1'b1, tap_x: 12'd100, tap_y: 12'd200, any_action: 1'b1, default: '0});
        // tap at the mouse release point, just inside the window
        add_row(1, 4095, 0, 0, 32'd2000, 1, NoAction);
        add_row(0, 0, 4095, 1, 32'd2299, 1,
                '{tap: 1'b1, tap_x: 12'd0, tap_y: 12'd4095, any_action: 1'b1, default: '0});
        // too many fingers, short: pause
        add_row(15, 1234, 567, 0, 32'd3000, 1, NoAction);
        add_row(0, 0, 0, 0, 32'd3499, 1, '{pause_request: 1'b1, any_action: 1'b1, default: '0});
        // horizontal drag: right then left, no action on release
        add_row(1, 1000, 500, 0, 32'd4000, 1, NoAction);
        add_row(1, 1022, 500, 0, 32'd4010, 0, NoAction);
        add_row(1, 1023, 500, 0, 32'd4020, 0, NoAction);
        add_row(1, 1063, 505, 0, 32'd4030, 0, NoAction);
        add_row(1, 1000, 495, 0, 32'd4040, 0, NoAction);
        add_row(0, 0, 0, 0, 32'd4050, 0, NoAction);
        // downward flick across the timestamp wrap
        add_row(1, 500, 100, 0, 32'hFFFF_FF00, 1, NoAction);
        add_row(1, 500, 133, 0, 32'hFFFF_FF40, 0, NoAction);
        add_row(1, 500, 300, 0, 32'hFFFF_FF80, 0, NoAction);
        add_row(0, 0, 0, 0, 32'h0000_0010, 0, NoAction);
        // zero duration flick
        add_row(1, 3000, 3000, 0, 32'd7000, 1, NoAction);
        add_row(1, 3000, 3049, 0, 32'd7000, 0, NoAction);
        add_row(0, 0, 0, 0, 32'd7000, 0, NoAction);
        // two-finger sequence: motion ignored, long release gives nothing
        add_row(1, 2000, 2000, 0, 32'd5000, 1, NoAction);
        add_row(2, 2000, 2000, 0, 32'd5010, 1, NoAction);
        add_row(1, 2400, 2000, 0, 32'd5020, 1, NoAction);
        add_row(0, 2400, 2000, 1, 32'd5600, 1, NoAction);

        foreach (directed_rows[i])
            push_frame(directed_rows[i].frame, directed_rows[i].fixed, directed_rows[i].want);

        // Random part, one register setting per phase
        frame_clock_ms = $urandom();
        target         = frames_sent;
        for (int phase = 0; phase < 8; phase++) begin
            en = 1'b1;
            case (phase)
                0: step_val = tgc_pkg::StepReset;
                1: step_val = 10'd0;
                2: step_val = 10'd1023;
                3: step_val = 10'd7;
                4: begin
                    en       = 1'b0;
                    step_val = tgc_pkg::StepW'($urandom_range(0, 1023));
                end
                5: step_val = tgc_pkg::StepMin;
                6: step_val = tgc_pkg::StepW'($urandom_range(8, 1023));
                default: step_val = tgc_pkg::StepW'($urandom_range(8, 120));
            endcase
            drain();
            write_reg(tgc_pkg::CFG_ENABLE, {{(tgc_pkg::StepW-1){1'b0}}, en});
            write_reg(tgc_pkg::CFG_CELL_STEP, step_val);
            cfg_wr_en <= 1'b0;
            target += en ? 115 : 40;
            stp = (step_val < tgc_pkg::StepMin) ? int'(tgc_pkg::StepMin) : int'(step_val);
            while (frames_sent < target) play_gesture(stp);
        end

        no_idle = 1'b0;
        drain();
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
